@@ src/imufr_pkg.sv @@
// imufr_pkg: constants, register indexes and the report copy table for the
// sensor frame receiver and report generator; no dependencies
package imufr_pkg;

  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DEVICE_ADDRESS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FUNCTION_CODE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPORT_COMMAND  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TILT_LIMIT_DEG  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SAFE_MARGIN_DEG = 3'd4;

  localparam logic [7:0] RST_DEVICE_ADDRESS  = 8'h50;
  localparam logic [7:0] RST_FUNCTION_CODE   = 8'h03;
  localparam logic [7:0] RST_REPORT_COMMAND  = 8'h0C;
  localparam logic [6:0] RST_TILT_LIMIT_DEG  = 7'd20;
  localparam logic [4:0] RST_SAFE_MARGIN_DEG = 5'd5;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] REPORT_LEN = 8'd16;
  localparam logic [7:0] DELIM_BYTE = 8'h26;

  localparam int unsigned REPORT_BYTES = 18;
  localparam int unsigned IDX_W        = 5;
  localparam logic [IDX_W-1:0] IDX_CMD   = 5'd2;
  localparam logic [IDX_W-1:0] IDX_SYNC  = 5'd0;
  localparam logic [IDX_W-1:0] IDX_LEN   = 5'd1;
  localparam logic [IDX_W-1:0] IDX_SEQ   = 5'd3;
  localparam logic [IDX_W-1:0] IDX_DATA0 = 5'd4;
  localparam logic [IDX_W-1:0] IDX_DELIM = 5'd16;
  localparam logic [IDX_W-1:0] IDX_SUM   = 5'd17;

  // store bytes a report may read: the copy table reads only among the first 22
  localparam int unsigned RD_BYTES = 22;
  localparam int unsigned RD_ADDR_W = 5;

  // sensor data bytes of the report, in report order
  localparam int unsigned DATA_BYTES = 12;
  localparam int unsigned CP_W = 4;
  localparam logic [CP_W-1:0] CP_LAST = 4'd12;

  // positions of roll and pitch high bytes among the data bytes
  localparam int unsigned ROLL_HI  = 6;
  localparam int unsigned PITCH_HI = 8;

  function automatic logic [RD_ADDR_W-1:0] copy_addr(input logic [CP_W-1:0] k);
    logic [RD_ADDR_W-1:0] a;
    case (k)
      4'd0:    a = 5'd0;
      4'd1:    a = 5'd1;
      4'd2:    a = 5'd2;
      4'd3:    a = 5'd3;
      4'd4:    a = 5'd4;
      4'd5:    a = 5'd5;
      4'd6:    a = 5'd20;
      4'd7:    a = 5'd21;
      4'd8:    a = 5'd18;
      4'd9:    a = 5'd19;
      4'd10:   a = 5'd10;
      4'd11:   a = 5'd11;
      default: a = 5'd0;
    endcase
    return a;
  endfunction

endpackage

@@ src/imu_frame_receiver_and_reporter_top.sv @@
// imu_frame_receiver_and_reporter_top: sensor frame hunter with payload memory
// and a tilt-flagged 18-byte report generator; depends on imufr_pkg
//
// A received byte (op 0) is taken as soon as the input is free, and the input takes a new
// request every cycle while no report is under way. A send request (op 1)
// holds the input stalled while its report goes out at one byte per cycle
// while out_stall is low; when a complete frame is waiting, the 12 sensor
// bytes are first copied one per cycle through the single read port of the
// payload memory. The last report byte sits in the output register while the
// next request is already taken.
module imu_frame_receiver_and_reporter_top #(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic        out_tilt_stop,
  output logic        out_tilt_safe,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned ADDR_W = $clog2(BUF_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [2:0] RX_HUNT    = 3'd0;
  localparam logic [2:0] RX_FUNC    = 3'd1;
  localparam logic [2:0] RX_LEN     = 3'd2;
  localparam logic [2:0] RX_PAYLOAD = 3'd3;
  localparam logic [2:0] RX_DONE    = 3'd4;

  // configuration
  logic [7:0] dev_addr_r, func_code_r, cmd_r;
  logic [6:0] tilt_lim_r;
  logic [4:0] margin_r;
  logic [imufr_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= imufr_pkg::RST_DEVICE_ADDRESS;
      func_code_r <= imufr_pkg::RST_FUNCTION_CODE;
      cmd_r       <= imufr_pkg::RST_REPORT_COMMAND;
      tilt_lim_r  <= imufr_pkg::RST_TILT_LIMIT_DEG;
      margin_r    <= imufr_pkg::RST_SAFE_MARGIN_DEG;
    end else if (cfg_wr) begin
      case (reg_idx)
        imufr_pkg::REG_DEVICE_ADDRESS:  dev_addr_r  <= pwdata[7:0];
        imufr_pkg::REG_FUNCTION_CODE:   func_code_r <= pwdata[7:0];
        imufr_pkg::REG_REPORT_COMMAND:  cmd_r       <= pwdata[7:0];
        imufr_pkg::REG_TILT_LIMIT_DEG:  tilt_lim_r  <= pwdata[6:0];
        imufr_pkg::REG_SAFE_MARGIN_DEG: margin_r    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      imufr_pkg::REG_DEVICE_ADDRESS:  prdata = {24'd0, dev_addr_r};
      imufr_pkg::REG_FUNCTION_CODE:   prdata = {24'd0, func_code_r};
      imufr_pkg::REG_REPORT_COMMAND:  prdata = {24'd0, cmd_r};
      imufr_pkg::REG_TILT_LIMIT_DEG:  prdata = {25'd0, tilt_lim_r};
      imufr_pkg::REG_SAFE_MARGIN_DEG: prdata = {27'd0, margin_r};
      default:                        prdata = 32'd0;
    endcase
  end

  // control state
  logic [1:0] st_r, st_nxt;
  logic [2:0] rx_phase_r, rx_phase_nxt;
  logic [7:0] pay_len_r, pay_len_nxt;
  logic [7:0] pay_pos_r, pay_pos_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [imufr_pkg::CP_W-1:0] cp_r, cp_nxt;
  logic [imufr_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic out_last_r, out_stop_r, out_safe_r;

  logic in_acc, rx_acc, send_acc, load, store_wr;
  logic [7:0] pos_inc, cur_byte;

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rx_acc   = in_acc && !in_op;
  assign send_acc = in_acc && in_op;
  assign load     = (st_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign pos_inc  = pay_pos_r + 8'd1;
  assign store_wr = rx_acc && (rx_phase_r == RX_PAYLOAD)
                    && ({1'b0, pay_pos_r} < 9'(BUF_DEPTH));

  // payload memory with valid bits on the bytes a report reads
  logic [7:0] mem [BUF_DEPTH];
  logic [imufr_pkg::RD_BYTES-1:0] vld_r;
  logic [imufr_pkg::RD_ADDR_W-1:0] cp_addr;
  logic [7:0] rd_data_r;
  logic rd_vld_r;

  assign cp_addr = imufr_pkg::copy_addr(cp_r);

  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[pay_pos_r[ADDR_W-1:0]] <= in_rx_byte;
    end
    rd_data_r <= mem[ADDR_W'(cp_addr)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[cp_addr];
      if (store_wr && (pay_pos_r < 8'(imufr_pkg::RD_BYTES))) begin
        vld_r[pay_pos_r[imufr_pkg::RD_ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  // latched sensor bytes, in report order
  logic [7:0] wb_r [imufr_pkg::DATA_BYTES];
  logic [imufr_pkg::CP_W-1:0] cp_m1;

  assign cp_m1 = cp_r - 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < imufr_pkg::DATA_BYTES; i++) begin
        wb_r[i] <= 8'd0;
      end
    end else if ((st_r == ST_COPY) && (cp_r != 4'd0)) begin
      wb_r[cp_m1] <= rd_vld_r ? rd_data_r : 8'd0;
    end
  end

  // tilt flags
  logic signed [15:0] pitch_s, roll_s;
  logic signed [23:0] pitch_x, roll_x, lim_x, safe_x;
  logic signed [8:0]  diff_s;
  logic stop_f, safe_f;

  assign pitch_s = {wb_r[imufr_pkg::PITCH_HI], wb_r[imufr_pkg::PITCH_HI+1]};
  assign roll_s  = {wb_r[imufr_pkg::ROLL_HI], wb_r[imufr_pkg::ROLL_HI+1]};
  assign pitch_x = 24'(pitch_s) * 24'sd180;
  assign roll_x  = 24'(roll_s) * 24'sd180;
  assign lim_x   = $signed({2'b00, tilt_lim_r, 15'd0});
  assign diff_s  = $signed({2'b00, tilt_lim_r}) - $signed({4'd0, margin_r});
  assign safe_x  = {diff_s, 15'd0};
  assign stop_f  = (pitch_x > lim_x) || (pitch_x < -lim_x)
                   || (roll_x > lim_x) || (roll_x < -lim_x);
  assign safe_f  = (pitch_x < safe_x) && (pitch_x > -safe_x)
                   && (roll_x < safe_x) && (roll_x > -safe_x);

  // report byte select
  logic [imufr_pkg::CP_W-1:0] em_off;
  logic [imufr_pkg::IDX_W-1:0] em_diff;

  assign em_diff = idx_r - imufr_pkg::IDX_DATA0;
  assign em_off  = em_diff[imufr_pkg::CP_W-1:0];

  always_comb begin
    case (idx_r)
      imufr_pkg::IDX_SYNC:  cur_byte = imufr_pkg::SYNC_BYTE;
      imufr_pkg::IDX_LEN:   cur_byte = imufr_pkg::REPORT_LEN;
      imufr_pkg::IDX_CMD:   cur_byte = cmd_r;
      imufr_pkg::IDX_SEQ:   cur_byte = seq_r;
      imufr_pkg::IDX_DELIM: cur_byte = imufr_pkg::DELIM_BYTE;
      imufr_pkg::IDX_SUM:   cur_byte = sum_r;
      default:              cur_byte = wb_r[em_off];
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    rx_phase_nxt  = rx_phase_r;
    pay_len_nxt   = pay_len_r;
    pay_pos_nxt   = pay_pos_r;
    seq_nxt       = seq_r;
    sum_nxt       = sum_r;
    cp_nxt        = cp_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;

    // frame hunter
    if (rx_acc) begin
      case (rx_phase_r)
        RX_HUNT: begin
          if (in_rx_byte == dev_addr_r) rx_phase_nxt = RX_FUNC;
        end
        RX_FUNC: begin
          rx_phase_nxt = (in_rx_byte == func_code_r) ? RX_LEN : RX_HUNT;
        end
        RX_LEN: begin
          pay_len_nxt  = in_rx_byte;
          pay_pos_nxt  = 8'd0;
          rx_phase_nxt = RX_PAYLOAD;
        end
        RX_PAYLOAD: begin
          pay_pos_nxt = pos_inc;
          if (pos_inc >= pay_len_r) rx_phase_nxt = RX_DONE;
        end
        default: ;
      endcase
    end

    case (st_r)
      ST_IDLE: begin
        if (send_acc) begin
          idx_nxt = '0;
          sum_nxt = 8'd0;
          cp_nxt  = '0;
          if (rx_phase_r == RX_DONE) begin
            rx_phase_nxt = RX_HUNT;
            st_nxt       = ST_COPY;
          end else begin
            st_nxt = ST_EMIT;
          end
        end
      end
      ST_COPY: begin
        cp_nxt = cp_r + 4'd1;
        if (cp_r == imufr_pkg::CP_LAST) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          sum_nxt       = sum_r + cur_byte;
          idx_nxt       = idx_r + 5'd1;
          if (idx_r == imufr_pkg::IDX_SEQ) seq_nxt = seq_r + 8'd1;
          if (idx_r == imufr_pkg::IDX_SUM) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rx_phase_r  <= RX_HUNT;
      pay_len_r   <= 8'd0;
      pay_pos_r   <= 8'd0;
      seq_r       <= 8'd0;
      sum_r       <= 8'd0;
      cp_r        <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rx_phase_r  <= rx_phase_nxt;
      pay_len_r   <= pay_len_nxt;
      pay_pos_r   <= pay_pos_nxt;
      seq_r       <= seq_nxt;
      sum_r       <= sum_nxt;
      cp_r        <= cp_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= (idx_r == imufr_pkg::IDX_SUM);
      out_stop_r <= stop_f;
      out_safe_r <= safe_f;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_last      = out_last_r;
  assign out_tilt_stop = out_stop_r;
  assign out_tilt_safe = out_safe_r;

endmodule
